@@ design/gdo_pkg.sv @@
// Shared widths, constants, command/status types and calendar tables for the date offset block.
package gdo_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 16;
  localparam int SER_W   = 22;  // day serial from 0001-01-01, last one is 3652058
  localparam int SUM_W   = 24;  // signed serial plus offset
  localparam int RD_W    = 9;   // day within a year, 0..365

  localparam int YEAR_MAX    = 9999;
  localparam int MONTH_MAX   = 12;
  localparam int MAX_OFFSET  = 32767;
  localparam int LAST_SERIAL = 3652058;  // serial of 9999-12-31

  // floor(p / 100) as (p * RECIP_100) >> RECIP_100_SH, exact for p below 10000
  localparam int RECIP_100    = 5243;
  localparam int RECIP_100_SH = 19;
  // year estimate: (serial * RECIP_YEAR) >> RECIP_YEAR_SH, never below serial / 365.2425
  localparam int RECIP_YEAR    = 2871;
  localparam int RECIP_YEAR_SH = 20;

  typedef struct packed {
    logic load;         // capture a new item
    logic yu_sel_walk;  // year unit input: walked year instead of start year
    logic day_calc;     // clamp start day, form start serial
    logic sum_calc;     // add offset, saturate, compare
    logic est_calc;     // first guess of the result year
    logic walk_dec;     // step the guessed year down
    logic walk_fin;     // year found, keep day-of-year
    logic month_step;   // take one month off the day-of-year
    logic out_load;     // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic year_high;    // guessed year starts after the result serial
    logic month_more;   // day-of-year still past the current month
  } sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m
  function automatic logic [RD_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    logic [RD_W-1:0] base;
    unique case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

@@ design/gregorian_date_offset.sv @@
// Top level: Gregorian date plus signed day offset, with range saturation.
//
//   channel  direction  payload                                              handshake
//   in_      input      start_year, start_month, start_day, offset_days      in_valid/in_ready
//   out_     output     result_year, result_month, result_day,               out_valid/out_ready
//                       is_before_start, range_error
//
// One item is in work at a time. From the input transfer to a result sitting in the output
// register, the time is set by the year probe loop (one probe per guessed year through the
// two-stage year unit, 1 to 3 probes) and by the month walk.
// A new input transfer is taken in the cycle after the result is loaded, even while that
// result still waits for out_ready; a full output register holds the finished item back.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any pending result.
module gregorian_date_offset (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gdo_pkg::YEAR_W-1:0]        in_start_year,
  input  logic [gdo_pkg::MONTH_W-1:0]       in_start_month,
  input  logic [gdo_pkg::DAY_W-1:0]         in_start_day,
  input  logic signed [gdo_pkg::OFF_W-1:0]  in_offset_days,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [gdo_pkg::YEAR_W-1:0]        out_result_year,
  output logic [gdo_pkg::MONTH_W-1:0]       out_result_month,
  output logic [gdo_pkg::DAY_W-1:0]         out_result_day,
  output logic                              out_is_before_start,
  output logic                              out_range_error
);

  gdo_pkg::cmd_t cmd;
  gdo_pkg::sts_t sts;

  // Sequencer: clamp, start serial, offset add, year guess, year probe, month walk.
  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Serial-day arithmetic; the output register lives here and is loaded on cmd.out_load.
  gdo_datapath u_dp (
    .clk                 (clk),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_start_year       (in_start_year),
    .in_start_month      (in_start_month),
    .in_start_day        (in_start_day),
    .in_offset_days      (in_offset_days),
    .out_result_year     (out_result_year),
    .out_result_month    (out_result_month),
    .out_result_day      (out_result_day),
    .out_is_before_start (out_is_before_start),
    .out_range_error     (out_range_error)
  );

endmodule

@@ design/gdo_year_unit.sv @@
// Two-stage unit: days before the first of a year, and that year's leap flag.
module gdo_year_unit (
  input  logic                      clk,
  input  logic [gdo_pkg::YEAR_W-1:0] year_in,
  output logic [gdo_pkg::SER_W-1:0]  dby,
  output logic                      leap
);

  localparam int PROD_W = 27;

  logic [gdo_pkg::YEAR_W-1:0] p;
  logic [PROD_W-1:0]          prod;
  logic [gdo_pkg::YEAR_W-1:0] p_r;
  logic [6:0]                 qp_r;
  logic [gdo_pkg::YEAR_W-1:0] rp;
  logic [6:0]                 qp1;
  logic [gdo_pkg::SER_W-1:0]  dby_nxt;
  logic                       leap_nxt;
  logic [gdo_pkg::SER_W-1:0]  dby_r;
  logic                       leap_r;

  // stage one: p = year - 1 and p / 100
  always_comb begin
    p    = year_in - 14'd1;
    prod = PROD_W'(p) * PROD_W'(gdo_pkg::RECIP_100);
  end

  always_ff @(posedge clk) begin
    p_r  <= p;
    qp_r <= prod[gdo_pkg::RECIP_100_SH +: 7];
  end

  // stage two: 365p + p/4 - p/100 + p/400; year divisible by 100 when p ends in 99
  always_comb begin
    rp       = p_r - (14'(qp_r) * 14'd100);
    qp1      = qp_r + 7'd1;
    dby_nxt  = (22'(p_r) * 22'd365) + 22'(p_r >> 2) - 22'(qp_r) + 22'(qp_r >> 2);
    leap_nxt = (p_r[1:0] == 2'd3) && ((rp != 14'd99) || (qp1[1:0] == 2'd0));
  end

  always_ff @(posedge clk) begin
    dby_r  <= dby_nxt;
    leap_r <= leap_nxt;
  end

  assign dby  = dby_r;
  assign leap = leap_r;

endmodule

@@ design/gdo_datapath.sv @@
// Datapath: input clamp, serial arithmetic, year and month walk, output register.
module gdo_datapath (
  input  logic                              clk,
  input  gdo_pkg::cmd_t                     cmd,
  output gdo_pkg::sts_t                     sts,
  input  logic [gdo_pkg::YEAR_W-1:0]        in_start_year,
  input  logic [gdo_pkg::MONTH_W-1:0]       in_start_month,
  input  logic [gdo_pkg::DAY_W-1:0]         in_start_day,
  input  logic signed [gdo_pkg::OFF_W-1:0]  in_offset_days,
  output logic [gdo_pkg::YEAR_W-1:0]        out_result_year,
  output logic [gdo_pkg::MONTH_W-1:0]       out_result_month,
  output logic [gdo_pkg::DAY_W-1:0]         out_result_day,
  output logic                              out_is_before_start,
  output logic                              out_range_error
);

  localparam int EST_W = 2 * gdo_pkg::SER_W - 10;  // 34-bit product
  localparam logic signed [gdo_pkg::SUM_W-1:0] OFF_LIM = gdo_pkg::SUM_W'(gdo_pkg::MAX_OFFSET);
  localparam logic signed [gdo_pkg::SUM_W-1:0] LAST_S  = gdo_pkg::SUM_W'(gdo_pkg::LAST_SERIAL);

  logic [gdo_pkg::YEAR_W-1:0]        sy_r, wy_r;
  logic [gdo_pkg::MONTH_W-1:0]       sm_r, rm_r;
  logic [gdo_pkg::DAY_W-1:0]         sd_r;
  logic signed [gdo_pkg::OFF_W-1:0]  off_r;
  logic [gdo_pkg::SER_W-1:0]         ss_r, rs_r;
  logic [gdo_pkg::RD_W-1:0]          rd_r;
  logic                              err_r, before_r, leap_r;

  logic [gdo_pkg::YEAR_W-1:0]        yu_in;
  logic [gdo_pkg::SER_W-1:0]         yu_dby;
  logic                              yu_leap;

  logic [gdo_pkg::YEAR_W-1:0]        y_cl;
  logic [gdo_pkg::MONTH_W-1:0]       m_cl;
  logic signed [gdo_pkg::SUM_W-1:0]  off_ext;
  logic signed [gdo_pkg::OFF_W-1:0]  off_sat;
  logic [gdo_pkg::DAY_W-1:0]         ml_start, d_cl;
  logic [gdo_pkg::SER_W-1:0]         ss_nxt;
  logic signed [gdo_pkg::SUM_W-1:0]  sum;
  logic [gdo_pkg::SER_W-1:0]         rs_nxt;
  logic                              err_nxt;
  logic [EST_W-1:0]                  est_prod;
  logic [gdo_pkg::YEAR_W:0]          est2;
  logic [gdo_pkg::YEAR_W-1:0]        wy_est;
  logic [gdo_pkg::DAY_W-1:0]         ml_walk;

  assign yu_in = cmd.yu_sel_walk ? wy_r : sy_r;

  gdo_year_unit u_year (
    .clk     (clk),
    .year_in (yu_in),
    .dby     (yu_dby),
    .leap    (yu_leap)
  );

  always_comb begin
    // input clamp and offset saturation
    if (in_start_year == '0)
      y_cl = 14'd1;
    else if (in_start_year > 14'(gdo_pkg::YEAR_MAX))
      y_cl = 14'(gdo_pkg::YEAR_MAX);
    else
      y_cl = in_start_year;
    if (in_start_month == '0)
      m_cl = 4'd1;
    else if (in_start_month > 4'(gdo_pkg::MONTH_MAX))
      m_cl = 4'(gdo_pkg::MONTH_MAX);
    else
      m_cl = in_start_month;
    off_ext = gdo_pkg::SUM_W'(in_offset_days);
    if (off_ext > OFF_LIM)
      off_sat = gdo_pkg::OFF_W'(OFF_LIM);
    else if (off_ext < -OFF_LIM)
      off_sat = gdo_pkg::OFF_W'(-OFF_LIM);
    else
      off_sat = in_offset_days;

    // start serial
    ml_start = gdo_pkg::month_len(sm_r, yu_leap);
    if (sd_r == '0)
      d_cl = 5'd1;
    else if (sd_r > ml_start)
      d_cl = ml_start;
    else
      d_cl = sd_r;
    ss_nxt = yu_dby + 22'(gdo_pkg::cum_days(sm_r, yu_leap)) + 22'(d_cl) - 22'd1;

    // result serial, saturated to the calendar range
    sum = $signed({2'b00, ss_r}) + gdo_pkg::SUM_W'(off_r);
    if (sum < 0) begin
      rs_nxt  = '0;
      err_nxt = 1'b1;
    end else if (sum > LAST_S) begin
      rs_nxt  = gdo_pkg::SER_W'(gdo_pkg::LAST_SERIAL);
      err_nxt = 1'b1;
    end else begin
      rs_nxt  = gdo_pkg::SER_W'(sum);
      err_nxt = 1'b0;
    end

    // year guess at or just above the true year
    est_prod = EST_W'(rs_r) * EST_W'(gdo_pkg::RECIP_YEAR);
    est2     = {1'b0, est_prod[gdo_pkg::RECIP_YEAR_SH +: gdo_pkg::YEAR_W]} + 15'd2;
    wy_est   = (est2 > 15'(gdo_pkg::YEAR_MAX)) ? 14'(gdo_pkg::YEAR_MAX)
                                               : est2[gdo_pkg::YEAR_W-1:0];

    ml_walk = gdo_pkg::month_len(rm_r, leap_r);
  end

  always_comb begin
    sts.year_high  = (yu_dby > rs_r) && (wy_r != 14'd1);
    sts.month_more = (rm_r < 4'(gdo_pkg::MONTH_MAX)) && (rd_r >= 9'(ml_walk));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sy_r  <= y_cl;
      sm_r  <= m_cl;
      sd_r  <= in_start_day;
      off_r <= off_sat;
    end
    if (cmd.day_calc)
      ss_r <= ss_nxt;
    if (cmd.sum_calc) begin
      rs_r     <= rs_nxt;
      err_r    <= err_nxt;
      before_r <= rs_nxt < ss_r;
    end
    if (cmd.est_calc)
      wy_r <= wy_est;
    else if (cmd.walk_dec)
      wy_r <= wy_r - 14'd1;
    if (cmd.walk_fin) begin
      rd_r   <= 9'(rs_r - yu_dby);
      rm_r   <= 4'd1;
      leap_r <= yu_leap;
    end else if (cmd.month_step) begin
      rd_r <= rd_r - 9'(ml_walk);
      rm_r <= rm_r + 4'd1;
    end
    if (cmd.out_load) begin
      out_result_year     <= wy_r;
      out_result_month    <= rm_r;
      out_result_day      <= 5'(rd_r + 9'd1);
      out_is_before_start <= before_r;
      out_range_error     <= err_r;
    end
  end

endmodule

@@ design/gdo_ctrl.sv @@
// Controller: sequences one date item through the datapath and owns both handshakes.
module gdo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gdo_pkg::sts_t sts,
  output gdo_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_YS0  = 4'd1;
  localparam logic [3:0] S_YS1  = 4'd2;
  localparam logic [3:0] S_DAY  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_EST  = 4'd5;
  localparam logic [3:0] S_WA   = 4'd6;
  localparam logic [3:0] S_WB   = 4'd7;
  localparam logic [3:0] S_WC   = 4'd8;
  localparam logic [3:0] S_MON  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load  = 1'b1;
        state_nxt = S_YS0;
      end
      S_YS0: state_nxt = S_YS1;
      S_YS1: state_nxt = S_DAY;
      S_DAY: begin
        cmd.day_calc = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_calc = 1'b1;
        state_nxt    = S_EST;
      end
      S_EST: begin
        cmd.est_calc = 1'b1;
        state_nxt    = S_WA;
      end
      S_WA: begin
        cmd.yu_sel_walk = 1'b1;
        state_nxt       = S_WB;
      end
      S_WB: state_nxt = S_WC;
      S_WC: begin
        if (sts.year_high) begin
          cmd.walk_dec = 1'b1;
          state_nxt    = S_WA;
        end else begin
          cmd.walk_fin = 1'b1;
          state_nxt    = S_MON;
        end
      end
      S_MON: begin
        if (sts.month_more)
          cmd.month_step = 1'b1;
        else
          state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.out_load)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ bench/date_offset_checker.sv @@
// Checker for the date offset block: watches both channels, predicts each result, compares.
`timescale 1ns / 100ps

module date_offset_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [gdo_pkg::YEAR_W-1:0]        in_start_year,
  input  logic [gdo_pkg::MONTH_W-1:0]       in_start_month,
  input  logic [gdo_pkg::DAY_W-1:0]         in_start_day,
  input  logic signed [gdo_pkg::OFF_W-1:0]  in_offset_days,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [gdo_pkg::YEAR_W-1:0]        out_result_year,
  input  logic [gdo_pkg::MONTH_W-1:0]       out_result_month,
  input  logic [gdo_pkg::DAY_W-1:0]         out_result_day,
  input  logic                              out_is_before_start,
  input  logic                              out_range_error,
  output int                                fail_count,
  output int                                n_pending
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [gdo_pkg::YEAR_W-1:0]  year;
    logic [gdo_pkg::MONTH_W-1:0] month;
    logic [gdo_pkg::DAY_W-1:0]   day;
    logic                        is_before;
    logic                        range_err;
  } shifted_date_t;

  shifted_date_t shifted_date_q[$];

  function automatic int days_in_month(input int y, input int m);
    int len;
    case (m)
      2: begin
        len = (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
      end
      4, 6, 9, 11: len = 30;
      default:     len = 31;
    endcase
    return len;
  endfunction

  // serial of January 1st of year y, counted from 0001-01-01
  function automatic int year_start_serial(input int y);
    int p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic shifted_date_t predict_shifted_date(
      input logic [gdo_pkg::YEAR_W-1:0]       y_in,
      input logic [gdo_pkg::MONTH_W-1:0]      m_in,
      input logic [gdo_pkg::DAY_W-1:0]        d_in,
      input logic signed [gdo_pkg::OFF_W-1:0] off_in);
    int y, m, d, off, k, start_ser, res_ser, last_ser, doy;
    shifted_date_t r;
    y = int'(y_in);
    m = int'(m_in);
    d = int'(d_in);
    off = int'(off_in);
    // clamp the start date into the calendar
    if (y < 1) y = 1;
    if (y > gdo_pkg::YEAR_MAX) y = gdo_pkg::YEAR_MAX;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > days_in_month(y, m)) d = days_in_month(y, m);
    if (off > gdo_pkg::MAX_OFFSET) off = gdo_pkg::MAX_OFFSET;
    if (off < -gdo_pkg::MAX_OFFSET) off = -gdo_pkg::MAX_OFFSET;

    start_ser = year_start_serial(y);
    for (k = 1; k < m; k++) start_ser += days_in_month(y, k);
    start_ser += d - 1;

    res_ser = start_ser + off;
    last_ser = year_start_serial(gdo_pkg::YEAR_MAX + 1) - 1;
    r.range_err = 1'b0;
    if (res_ser < 0) begin
      res_ser = 0;
      r.range_err = 1'b1;
    end else if (res_ser > last_ser) begin
      res_ser = last_ser;
      r.range_err = 1'b1;
    end

    // start low (366-day years) and walk up to the year holding the serial
    y = res_ser / 366 + 1;
    while (year_start_serial(y + 1) <= res_ser) y++;
    doy = res_ser - year_start_serial(y);
    m = 1;
    while (m < 12 && doy >= days_in_month(y, m)) begin
      doy -= days_in_month(y, m);
      m++;
    end

    r.year      = gdo_pkg::YEAR_W'(y);
    r.month     = gdo_pkg::MONTH_W'(m);
    r.day       = gdo_pkg::DAY_W'(doy + 1);
    r.is_before = (res_ser < start_ser);
    return r;
  endfunction

  always @(posedge clk) begin : watch_proc
    shifted_date_t want, got;
    if (!rst_n) begin
      shifted_date_q.delete();
      fail_count <= 0;
      n_pending  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_result_year, out_result_month, out_result_day,
               out_is_before_start, out_range_error};
        if (shifted_date_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: result with nothing expected: %0d-%0d-%0d before=%b err=%b",
                     $time, got.year, got.month, got.day, got.is_before, got.range_err);
          fail_count <= fail_count + 1;
        end else begin
          want = shifted_date_q.pop_front();
          if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
              got.is_before !== want.is_before || got.range_err !== want.range_err) begin
            if (fail_count < MAX_REPORTS)
              $display({"%0t: mismatch: expected %0d-%0d-%0d before=%b err=%b, ",
                        "got %0d-%0d-%0d before=%b err=%b"},
                       $time, want.year, want.month, want.day, want.is_before,
                       want.range_err, got.year, got.month, got.day, got.is_before,
                       got.range_err);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        shifted_date_q.push_back(predict_shifted_date(in_start_year, in_start_month,
                                                      in_start_day, in_offset_days));
      n_pending <= shifted_date_q.size();
    end
  end

endmodule

@@ bench/gregorian_date_offset_tb.sv @@
// Testbench top for the date offset block: clock, reset, stimulus, handshake pressure, verdict.
`timescale 1ns / 100ps

module gregorian_date_offset_tb;

  localparam int ITEMS_PER_PHASE = 112;
  localparam int WATCHDOG_LIMIT  = 4000;  // idle cycles without any transfer
  localparam int TAIL_CYCLES     = 60;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [gdo_pkg::YEAR_W-1:0]        in_start_year;
  logic [gdo_pkg::MONTH_W-1:0]       in_start_month;
  logic [gdo_pkg::DAY_W-1:0]         in_start_day;
  logic signed [gdo_pkg::OFF_W-1:0]  in_offset_days;
  logic                              out_valid;
  logic                              out_ready;
  logic [gdo_pkg::YEAR_W-1:0]        out_result_year;
  logic [gdo_pkg::MONTH_W-1:0]       out_result_month;
  logic [gdo_pkg::DAY_W-1:0]         out_result_day;
  logic                              out_is_before_start;
  logic                              out_range_error;

  int fail_count;
  int n_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  gregorian_date_offset u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_year       (in_start_year),
    .in_start_month      (in_start_month),
    .in_start_day        (in_start_day),
    .in_offset_days      (in_offset_days),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_year     (out_result_year),
    .out_result_month    (out_result_month),
    .out_result_day      (out_result_day),
    .out_is_before_start (out_is_before_start),
    .out_range_error     (out_range_error)
  );

  date_offset_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_year       (in_start_year),
    .in_start_month      (in_start_month),
    .in_start_day        (in_start_day),
    .in_offset_days      (in_offset_days),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_year     (out_result_year),
    .out_result_month    (out_result_month),
    .out_result_day      (out_result_day),
    .out_is_before_start (out_is_before_start),
    .out_range_error     (out_range_error),
    .fail_count          (fail_count),
    .n_pending           (n_pending)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Count cycles with no transfer on either channel; end the run if the block hangs.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Present one start date and offset, then hold it until the transfer.
  // Lower valid only when a gap is taken, so back-to-back items keep it high.
  task automatic send_date(input logic [gdo_pkg::YEAR_W-1:0]       y,
                           input logic [gdo_pkg::MONTH_W-1:0]      m,
                           input logic [gdo_pkg::DAY_W-1:0]        d,
                           input logic signed [gdo_pkg::OFF_W-1:0] off);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    in_start_year  <= y;
    in_start_month <= m;
    in_start_day   <= d;
    in_offset_days <= off;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every expected result has been seen.
  // Wait for the next edge first so the checker's pending count covers the last transfer.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  initial begin : stim_proc
    logic [gdo_pkg::YEAR_W-1:0]       y;
    logic [gdo_pkg::MONTH_W-1:0]      m;
    logic [gdo_pkg::DAY_W-1:0]        d;
    logic signed [gdo_pkg::OFF_W-1:0] off;
    int ph, n;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_start_year  <= '0;
    in_start_month <= '0;
    in_start_day   <= '0;
    in_offset_days <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: calendar edges, clamping of each start field, saturation.
    send_date(14'd1,     4'd1,  5'd1,  16'sd0);       // first day, no move
    send_date(14'd1,     4'd1,  5'd1,  -16'sd1);      // below the first day
    send_date(14'd1,     4'd1,  5'd1,  -16'sd32767);
    send_date(14'd1,     4'd1,  5'd1,  16'sd32767);
    send_date(14'd9999,  4'd12, 5'd31, 16'sd1);       // past the last day
    send_date(14'd9999,  4'd12, 5'd31, 16'sd32767);
    send_date(14'd9999,  4'd12, 5'd31, -16'sd1);
    send_date(14'd9999,  4'd12, 5'd31, -16'sd32767);
    send_date(14'd2000,  4'd1,  5'd1,  16'sh8000);    // most negative offset saturates
    send_date(14'd0,     4'd6,  5'd15, 16'sd10);      // year zero taken as one
    send_date(14'd16383, 4'd6,  5'd15, -16'sd10);     // year above range
    send_date(14'd2020,  4'd0,  5'd10, 16'sd5);       // month zero
    send_date(14'd2020,  4'd15, 5'd10, 16'sd5);       // month above range
    send_date(14'd2021,  4'd3,  5'd0,  16'sd0);       // day zero
    send_date(14'd2023,  4'd2,  5'd31, 16'sd0);       // day past end, common year
    send_date(14'd2024,  4'd2,  5'd31, 16'sd0);       // day past end, leap year
    send_date(14'd1900,  4'd2,  5'd29, 16'sd1);       // century, not leap
    send_date(14'd2000,  4'd2,  5'd28, 16'sd1);       // 400-year rule, leap
    send_date(14'd2000,  4'd2,  5'd29, 16'sd365);
    send_date(14'd2100,  4'd3,  5'd1,  -16'sd1);
    send_date(14'd2024,  4'd12, 5'd31, 16'sd1);       // year carry
    send_date(14'd2024,  4'd1,  5'd31, 16'sd30);
    send_date(14'd1996,  4'd3,  5'd1,  16'sd1461);    // walk through several Februaries
    send_date(14'd2004,  4'd3,  5'd1,  -16'sd1461);
    wait_results_drained();

    // Random part in four phases of differing idle and stall rates, with a full drain between phases.
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // bias years toward both ends of the range and toward century years
        case ($urandom_range(9))
          0: y = gdo_pkg::YEAR_W'($urandom_range(1, 120));
          1: y = gdo_pkg::YEAR_W'($urandom_range(9880, 9999));
          2: y = gdo_pkg::YEAR_W'(100 * $urandom_range(1, 99));
          3: y = gdo_pkg::YEAR_W'(400 * $urandom_range(1, 24));
          4: y = gdo_pkg::YEAR_W'($urandom);  // any code, out-of-range ones too
          default: y = gdo_pkg::YEAR_W'($urandom_range(1, 9999));
        endcase
        if ($urandom_range(99) < 15) m = gdo_pkg::MONTH_W'($urandom);
        else m = gdo_pkg::MONTH_W'($urandom_range(1, 12));
        if ($urandom_range(99) < 15) d = gdo_pkg::DAY_W'($urandom);
        else d = gdo_pkg::DAY_W'($urandom_range(1, 31));
        case ($urandom_range(7))
          0: off = gdo_pkg::OFF_W'($urandom);
          1: begin
            case ($urandom_range(2))
              0: off = 16'sh7FFF;
              1: off = -16'sd32767;
              default: off = 16'sh8000;
            endcase
          end
          2, 3: off = gdo_pkg::OFF_W'(int'($urandom_range(0, 800)) - 400);
          4: off = gdo_pkg::OFF_W'(int'($urandom_range(0, 120)) - 60);
          default: off = gdo_pkg::OFF_W'(int'($urandom_range(0, 65534)) - 32767);
        endcase
        send_date(y, m, d, off);
      end
      wait_results_drained();
    end

    // Release the result channel and let any stray result show up.
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && n_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/gdo_pkg.sv
design/gdo_year_unit.sv
design/gdo_datapath.sv
design/gdo_ctrl.sv
design/gregorian_date_offset.sv
bench/date_offset_checker.sv
bench/gregorian_date_offset_tb.sv
